FILE: hdl/page_frame_lookup_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Page frame lookup table assertion macros
// Clocked, reset-qualified assertion wrappers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_LOOKUP_TABLE_UNIT_MACROS_SVH
`define PAGE_FRAME_LOOKUP_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define PFLT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PFLT_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PFLT_ASSERT(label, prop, msg)
`define PFLT_ASSERT_NEVER(label, cond, msg)
`endif

`endif

FILE: hdl/pflt_pkg.sv
// ----------------------------------------------------------------------------
// Page frame lookup table package
// Field widths, command and status codes, and the words passed between cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pflt_pkg;

  localparam int unsigned PfltEntries = 64;
  localparam int unsigned CmdW        = 2;
  localparam int unsigned FileW       = 16;
  localparam int unsigned PageW       = 31;
  localparam int unsigned SlotW       = 10;
  localparam int unsigned StatusW     = 2;

  typedef enum logic [CmdW-1:0] {
    CmdSearch = 2'd0,
    CmdInsert = 2'd1,
    CmdRemove = 2'd2
  } pflt_cmd_e;

  typedef enum logic [StatusW-1:0] {
    StsOk       = 2'd0,
    StsNotFound = 2'd1,
    StsPresent  = 2'd2,
    StsFull     = 2'd3
  } pflt_status_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [FileW-1:0] file;
    logic [PageW-1:0] page;
    logic [SlotW-1:0] slot;
  } pflt_req_t;

  typedef struct packed {
    logic             active;
    logic             hit;
    logic             claimed;
    logic [SlotW-1:0] slot;
  } pflt_tok_t;

  typedef struct packed {
    logic fire;
    logic abort;
  } pflt_cmt_t;

  typedef struct packed {
    logic valid;
    logic tent;
  } pflt_stat_t;

endpackage

`default_nettype wire

FILE: hdl/pflt_cell.sv
// ----------------------------------------------------------------------------
// Page frame lookup table cell
// One table entry; compares the broadcast key as the token passes and hands
// the token on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module pflt_cell import pflt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pflt_req_t  req_i,
  input  pflt_cmt_t  cmt_i,
  input  pflt_tok_t  tok_i,
  output pflt_tok_t  tok_o,
  output pflt_stat_t stat_o
);

  logic             valid_q, valid_d;
  logic             tent_q, tent_d;
  logic [FileW-1:0] file_q;
  logic [PageW-1:0] page_q;
  logic [SlotW-1:0] slot_q;
  pflt_tok_t        tok_q, tok_d;
  logic             match;
  logic             wr;

  assign match = valid_q && (req_i.file == file_q) && (req_i.page == page_q);

  always_comb begin
    valid_d = valid_q;
    tent_d  = tent_q;
    wr      = 1'b0;
    tok_d   = tok_i;
    if (tok_i.active) begin
      if (match) begin
        tok_d.hit  = 1'b1;
        tok_d.slot = slot_q;
      end
      if ((req_i.cmd == CmdInsert) && !valid_q && !tok_i.claimed && !tok_i.hit) begin
        wr            = 1'b1;
        valid_d       = 1'b1;
        tent_d        = 1'b1;
        tok_d.claimed = 1'b1;
      end
      if ((req_i.cmd == CmdRemove) && match) begin
        valid_d = 1'b0;
      end
    end
    if (cmt_i.fire) begin
      tent_d = 1'b0;
      if (cmt_i.abort && tent_q) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tent_q  <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tent_q  <= tent_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      file_q <= req_i.file;
      page_q <= req_i.page;
      slot_q <= req_i.slot;
    end
  end

  assign tok_o        = tok_q;
  assign stat_o.valid = valid_q;
  assign stat_o.tent  = tent_q;

endmodule

`default_nettype wire

FILE: hdl/page_frame_lookup_table_unit.sv
// ----------------------------------------------------------------------------
// Page frame lookup table unit
// Fully associative (file id, page number) to buffer slot table built as a
// chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one word per command:
//   search, insert or remove of a key, with the slot to store on insert.
//   Output channel (out_valid_o / out_ready_i) returns one word per command:
//   a status and the slot found by a search.
//   A command passes through the launch register and then walks the cell
//   chain one cell per cycle; its result is loaded into the output register,
//   or into the hold register while the output stalls. A new command is
//   taken only once the unit is idle again, so commands never overlap.
//   An insert claims the lowest free cell on the way and drops the claim at
//   the end of the walk if the key turns up in a later cell.
//   When the receiver stalls, a finished result waits in the output register
//   and a new command may still be accepted and walked; it then holds its
//   result until the output register frees.
//   Reset clears every valid bit at once; the table is usable as soon as
//   reset is released.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_frame_lookup_table_unit_macros.svh"

module page_frame_lookup_table_unit import pflt_pkg::*; #(
  parameter int unsigned ENTRIES = PfltEntries
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CmdW-1:0]    command_i,
  input  logic [FileW-1:0]   file_id_i,
  input  logic [PageW-1:0]   page_num_i,
  input  logic [SlotW-1:0]   slot_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic [SlotW-1:0]   slot_out_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StHold = 3'b100
  } pflt_state_e;

  pflt_state_e        state_q, state_d;
  pflt_req_t          req_q;
  logic               launch_q;
  logic               accept;
  pflt_tok_t          tok [ENTRIES+1];
  pflt_tok_t          tail;
  pflt_cmt_t          cmt;
  pflt_stat_t         stat [ENTRIES];
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES-1:0] tent_vec;

  logic [StatusW-1:0] res_status;
  logic [SlotW-1:0]   res_slot;
  logic [StatusW-1:0] hold_status_q;
  logic [SlotW-1:0]   hold_slot_q;
  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] status_q;
  logic [SlotW-1:0]   slot_out_q;
  logic               out_free;
  logic               load_res;
  logic               load_hold;
  logic               save_hold;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.cmd  <= command_i;
      req_q.file <= file_id_i;
      req_q.page <= page_num_i;
      req_q.slot <= slot_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= 1'b0;
    end else begin
      launch_q <= accept;
    end
  end

  assign tok[0] = {launch_q, 1'b0, 1'b0, {SlotW{1'b0}}};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    pflt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req_q),
      .cmt_i  (cmt),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1]),
      .stat_o (stat[i])
    );
    assign valid_vec[i] = stat[i].valid;
    assign tent_vec[i]  = stat[i].tent;
  end

  assign tail      = tok[ENTRIES];
  assign cmt.fire  = tail.active;
  assign cmt.abort = tail.hit;

  always_comb begin
    res_status = StsNotFound;
    res_slot   = '0;
    unique case (req_q.cmd)
      CmdSearch: begin
        if (tail.hit) begin
          res_status = StsOk;
          res_slot   = tail.slot;
        end
      end
      CmdInsert: begin
        if (tail.hit) begin
          res_status = StsPresent;
        end else if (tail.claimed) begin
          res_status = StsOk;
        end else begin
          res_status = StsFull;
        end
      end
      CmdRemove: begin
        if (tail.hit) begin
          res_status = StsOk;
        end
      end
      default: begin
        res_status = StsNotFound;
      end
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    load_res  = 1'b0;
    load_hold = 1'b0;
    save_hold = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (tail.active) begin
          if (out_free) begin
            load_res = 1'b1;
            state_d  = StIdle;
          end else begin
            save_hold = 1'b1;
            state_d   = StHold;
          end
        end
      end
      StHold: begin
        if (out_free) begin
          load_hold = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_res || load_hold) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (save_hold) begin
      hold_status_q <= res_status;
      hold_slot_q   <= res_slot;
    end
    if (load_res) begin
      status_q   <= res_status;
      slot_out_q <= res_slot;
    end else if (load_hold) begin
      status_q   <= hold_status_q;
      slot_out_q <= hold_slot_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_out_o  = slot_out_q;

  `PFLT_ASSERT(a_accept_starts_walk, accept |=> (state_q == StRun), "accept did not start a walk")
  `PFLT_ASSERT(a_tail_in_run, tail.active |-> (state_q == StRun), "token left chain outside a walk")
  `PFLT_ASSERT(a_single_claim, $onehot0(tent_vec), "more than one cell holds a tentative claim")
  `PFLT_ASSERT(a_idle_no_claim, (state_q == StIdle) |-> (tent_vec == '0), "claim left open after a walk")
  `PFLT_ASSERT(a_full_means_full, (tail.active && (req_q.cmd == CmdInsert) && !tail.hit && !tail.claimed) |-> (&valid_vec), "full reported with a free cell")

endmodule

`default_nettype wire

FILE: dv/page_frame_lookup_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page frame lookup table unit testbench
// Sends search, insert and remove words and checks every returned word in
// order against a local copy of the table. Covers key extremes, partial key
// matches, duplicate and full inserts, unused commands, output stalls that
// back up the input, and random traffic over a shared key pool.
// ----------------------------------------------------------------------------
module page_frame_lookup_table_unit_tb import pflt_pkg::*; ();

  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned RxHoldCycles = 400;
  localparam int unsigned PoolSize     = 80;
  localparam int unsigned BiasSpan     = 75;

  localparam logic [CmdW-1:0]  CmdUnused = 2'd3;
  localparam logic [FileW-1:0] FileMax   = '1;
  localparam logic [PageW-1:0] PageMax   = '1;
  localparam logic [SlotW-1:0] SlotMax   = '1;

  typedef struct packed {
    pflt_status_e     status;
    logic [SlotW-1:0] slot;
  } lookup_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [CmdW-1:0]    command_i   = '0;
  logic [FileW-1:0]   file_id_i   = '0;
  logic [PageW-1:0]   page_num_i  = '0;
  logic [SlotW-1:0]   slot_in_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [SlotW-1:0]   slot_out_o;

  logic             tbl_valid [PfltEntries];
  logic [FileW-1:0] tbl_file  [PfltEntries];
  logic [PageW-1:0] tbl_page  [PfltEntries];
  logic [SlotW-1:0] tbl_slot  [PfltEntries];

  logic [FileW-1:0] pool_file [PoolSize];
  logic [PageW-1:0] pool_page [PoolSize];

  lookup_result_t pending_results[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;
  int holds_asked    = 0;
  int holds_done     = 0;
  int hold_left      = 0;

  page_frame_lookup_table_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .file_id_i   (file_id_i),
    .page_num_i  (page_num_i),
    .slot_in_i   (slot_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .slot_out_o  (slot_out_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic lookup_result_t apply_command(logic [CmdW-1:0] cmd,
                                                   logic [FileW-1:0] file,
                                                   logic [PageW-1:0] page,
                                                   logic [SlotW-1:0] slot);
    lookup_result_t res;
    int hit;
    int free_idx;
    res.status = StsNotFound;
    res.slot   = '0;
    hit        = -1;
    free_idx   = -1;
    for (int i = PfltEntries - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_file[i] == file && tbl_page[i] == page) hit = i;
      if (!tbl_valid[i]) free_idx = i;
    end
    case (cmd)
      CmdSearch: begin
        if (hit >= 0) begin
          res.status = StsOk;
          res.slot   = tbl_slot[hit];
        end
      end
      CmdInsert: begin
        if (hit >= 0) begin
          res.status = StsPresent;
        end else if (free_idx < 0) begin
          res.status = StsFull;
        end else begin
          tbl_valid[free_idx] = 1'b1;
          tbl_file[free_idx]  = file;
          tbl_page[free_idx]  = page;
          tbl_slot[free_idx]  = slot;
          res.status          = StsOk;
        end
      end
      CmdRemove: begin
        if (hit >= 0) begin
          tbl_valid[hit] = 1'b0;
          res.status     = StsOk;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_word(logic [CmdW-1:0] cmd, logic [FileW-1:0] file,
                           logic [PageW-1:0] page, logic [SlotW-1:0] slot);
    lookup_result_t res;
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, PfltEntries + 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    file_id_i  <= file;
    page_num_i <= page;
    slot_in_i  <= slot;
    do @(posedge clk_i); while (!in_ready_o);
    res = apply_command(cmd, file, page, slot);
    pending_results = {pending_results, res};
  endtask

  task automatic send_random_word(bit fill_bias);
    int roll;
    int pick;
    logic [CmdW-1:0]  cmd;
    logic [FileW-1:0] file;
    logic [PageW-1:0] page;
    roll = $urandom_range(0, 99);
    if (roll < 5) cmd = CmdUnused;
    else if (roll < (fill_bias ? 65 : 20)) cmd = CmdInsert;
    else if (roll < (fill_bias ? 75 : 65)) cmd = CmdRemove;
    else cmd = CmdSearch;
    if ($urandom_range(0, 9) != 0) begin
      pick = $urandom_range(0, PoolSize - 1);
      file = pool_file[pick];
      page = pool_page[pick];
    end else begin
      file = FileW'($urandom);
      page = PageW'($urandom);
    end
    send_word(cmd, file, page, SlotW'($urandom));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    send_word(CmdSearch, '0, '0, '0);
    send_word(CmdRemove, '0, '0, '0);
    send_word(CmdUnused, FileMax, PageMax, SlotMax);
    send_word(CmdInsert, '0, '0, '0);
    send_word(CmdInsert, FileMax, PageMax, SlotMax);
    send_word(CmdSearch, '0, '0, SlotMax);
    send_word(CmdSearch, FileMax, PageMax, '0);
    send_word(CmdInsert, '0, '0, 10'h005);
    send_word(CmdSearch, '0, PageMax, '0);
    send_word(CmdSearch, FileMax, '0, '0);
    send_word(CmdInsert, '0, PageMax, 10'h155);
    send_word(CmdInsert, FileMax, '0, 10'h2aa);
    send_word(CmdSearch, '0, PageMax, '0);
    send_word(CmdSearch, FileMax, '0, '0);
    send_word(CmdUnused, '0, '0, '0);
    send_word(CmdSearch, '0, '0, '0);
    send_word(CmdRemove, '0, '0, '0);
    send_word(CmdSearch, '0, '0, '0);
    send_word(CmdRemove, '0, '0, '0);
    send_word(CmdInsert, '0, '0, SlotMax);
    send_word(CmdSearch, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_full_table();
    logic [FileW-1:0] file;
    logic [PageW-1:0] page;
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    repeat (PfltEntries) begin
      send_word(CmdInsert, FileW'($urandom), PageW'($urandom), SlotW'($urandom));
    end
    send_word(CmdInsert, FileW'($urandom), PageW'($urandom), SlotW'($urandom));
    send_word(CmdInsert, tbl_file[5], tbl_page[5], SlotW'($urandom));
    send_word(CmdSearch, tbl_file[PfltEntries - 1], tbl_page[PfltEntries - 1], '0);
    send_word(CmdRemove, tbl_file[17], tbl_page[17], '0);
    file = FileW'($urandom);
    page = PageW'($urandom);
    send_word(CmdInsert, file, page, SlotW'($urandom));
    send_word(CmdSearch, file, page, '0);
    send_word(CmdInsert, FileW'($urandom), PageW'($urandom), SlotW'($urandom));
    for (int i = 0; i < PfltEntries; i++) begin
      if (tbl_valid[i]) send_word(CmdRemove, tbl_file[i], tbl_page[i], SlotW'($urandom));
    end
    wait_drained();
  endtask

  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    holds_asked <= holds_asked + 1;
    repeat (12) send_random_word(1'b1);
    wait_drained();
  endtask

  task automatic test_random_mix(int tx_pct, int rx_pct, int count);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    for (int n = 0; n < count; n++) send_random_word(((n / BiasSpan) % 2) == 0);
    wait_drained();
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      holds_done  <= 0;
    end else if (holds_done != holds_asked) begin
      holds_done  <= holds_done + 1;
      hold_left   <= RxHoldCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word status %0d slot %0d", $time, status_o, slot_out_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          mismatch_count++;
        end
        if (slot_out_o !== want.slot) begin
          $display("%0t: slot_out expected %0d actual %0d", $time, want.slot, slot_out_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < PfltEntries; i++) tbl_valid[i] = 1'b0;
    for (int i = 0; i < PoolSize; i++) begin
      case (i % 4)
        0: begin
          pool_file[i] = FileW'($urandom);
          pool_page[i] = PageW'($urandom);
        end
        1: begin
          pool_file[i] = pool_file[i - 1];
          pool_page[i] = PageW'($urandom);
        end
        2: begin
          pool_file[i] = FileW'($urandom);
          pool_page[i] = pool_page[i - 1];
        end
        default: begin
          pool_file[i] = $urandom_range(0, 1) ? FileMax : '0;
          case ($urandom_range(0, 2))
            0:       pool_page[i] = '0;
            1:       pool_page[i] = PageMax;
            default: pool_page[i] = PageW'($urandom);
          endcase
        end
      endcase
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_full_table();
    test_random_mix(18, 47, 400);
    test_random_mix(47, 18, 400);
    test_output_stall();
    test_random_mix(0, 0, 400);
    repeat (2 * PfltEntries + 8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: page_frame_lookup_table_unit.f
+incdir+hdl
hdl/pflt_pkg.sv
hdl/pflt_cell.sv
hdl/page_frame_lookup_table_unit.sv
dv/page_frame_lookup_table_unit_tb.sv
